### design/multiturn_angle_tracker_defines.svh
`ifndef MULTITURN_ANGLE_TRACKER_DEFINES_SVH
`define MULTITURN_ANGLE_TRACKER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MAT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MAT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/mat_pkg.sv
package mat_pkg;

    localparam int ANGLE_W = 14;
    localparam int SUM_W   = 18;
    localparam int CNT_W   = 5;
    localparam int RATE_W  = 10;
    localparam int DIFF_W  = 15;
    localparam int TOTAL_W = 32;
    localparam int SPEED_W = 24;
    localparam int LOW_W   = 6;

    localparam logic [RATE_W-1:0] RATE_RESET = 10'd10;
    localparam logic signed [DIFF_W:0] HALF_TURN = 16'sd8192;
    localparam logic signed [DIFF_W:0] FULL_TURN = 16'sd16384;

    typedef enum logic
    {
        FUNC_SAMPLE = 1'b0,
        FUNC_REPORT = 1'b1
    } func_t;

    typedef struct packed
    {
        logic               valid;
        logic [ANGLE_W-1:0] angle;
    } sample_beat_t;

endpackage

### design/mat_avg.sv
module mat_avg #(
    parameter int SAMPLES = 5
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mat_pkg::sample_beat_t          beat,
    output logic [mat_pkg::ANGLE_W-1:0]    position
);
    import mat_pkg::*;

    localparam int SHIFT = SUM_W + $clog2(SAMPLES);
    localparam int unsigned RECIP_INT = ((1 << SHIFT) + SAMPLES - 1) / SAMPLES;
    localparam logic [SHIFT:0] RECIP = RECIP_INT[SHIFT:0];
    localparam logic [CNT_W-1:0] COUNT_LIMIT = CNT_W'(SAMPLES);

    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [ANGLE_W-1:0]     pos_reg, pos_next;
    logic                   nonzero;
    logic [SUM_W-1:0]       sum_inc;
    logic [CNT_W-1:0]       cnt_inc;
    logic [SUM_W+SHIFT:0]   product;

    assign nonzero = beat.valid && (beat.angle != '0);
    assign sum_inc = sum_reg + (nonzero ? {{(SUM_W-ANGLE_W){1'b0}}, beat.angle} : '0);
    assign cnt_inc = cnt_reg + {{(CNT_W-1){1'b0}}, nonzero};
    assign product = {{(SHIFT+1){1'b0}}, sum_inc} * {{SUM_W{1'b0}}, RECIP};

    always_comb
    begin
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        pos_next = pos_reg;
        if (beat.valid)
        begin
            if (cnt_inc >= COUNT_LIMIT)
            begin
                sum_next = '0;
                cnt_next = '0;
                pos_next = product[SHIFT +: ANGLE_W];
            end
            else
            begin
                sum_next = sum_inc;
                cnt_next = cnt_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            cnt_reg <= '0;
            pos_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
            cnt_reg <= cnt_next;
            pos_reg <= pos_next;
        end
    end

    assign position = pos_reg;

endmodule

### design/multiturn_angle_tracker.sv
// Multiturn angle tracker. Sample beats (func 0) feed a running average of
// non-zero 14-bit angles; every SAMPLES of them set a new position. Report
// beats (func 1) return position, the wrapping 32-bit tick total and speed
// (wrapped tick step times report_rate_hz). The block takes one beat per
// cycle while input ready is high: a beat is held in the input register,
// then updates state and, for a report, loads the result register once
// that is free. Input ready drops only while a report waits behind a
// result not yet taken. Write report_rate_hz only when idle.
module multiturn_angle_tracker #(
    parameter int SAMPLES = 5
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                func,
    input  logic [7:0]                          angle_high,
    input  logic [7:0]                          angle_low,
    input  logic                                read_ok,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [mat_pkg::ANGLE_W-1:0]         position,
    output logic signed [mat_pkg::TOTAL_W-1:0]  total_ticks,
    output logic signed [mat_pkg::SPEED_W-1:0]  speed_q14,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mat_pkg::RATE_W-1:0]          report_rate_hz
);
    import mat_pkg::*;
    `include "multiturn_angle_tracker_defines.svh"

    logic                       s1_valid_reg, s1_valid_next;
    func_t                      s1_func_reg;
    logic [ANGLE_W-1:0]         s1_angle_reg;
    logic                       out_valid_reg, out_valid_next;
    logic [RATE_W-1:0]          rate_reg;
    logic [ANGLE_W-1:0]         last_reg;
    logic [TOTAL_W-1:0]         total_reg;
    logic signed [SPEED_W-1:0]  speed_reg;

    logic                       out_free;
    logic                       s1_advance;
    logic                       report_fire;
    logic                       in_fire;
    sample_beat_t               beat;
    logic [ANGLE_W-1:0]         cur_pos;
    logic signed [DIFF_W:0]     diff_raw;
    logic signed [DIFF_W:0]     diff_wrap;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [DIFF_W+RATE_W:0] speed_full;

    assign out_free    = !out_valid_reg || out_ready;
    assign s1_advance  = s1_valid_reg && ((s1_func_reg == FUNC_SAMPLE) || out_free);
    assign report_fire = s1_valid_reg && (s1_func_reg == FUNC_REPORT) && out_free;
    assign in_ready    = !s1_valid_reg || s1_advance;
    assign in_fire     = in_valid && in_ready;
    assign cfg_ready   = 1'b1;

    assign beat.valid = s1_valid_reg && (s1_func_reg == FUNC_SAMPLE);
    assign beat.angle = s1_angle_reg;

    mat_avg #(
        .SAMPLES (SAMPLES)
    ) u_avg (
        .clk      (clk),
        .rst_n    (rst_n),
        .beat     (beat),
        .position (cur_pos)
    );

    assign diff_raw = $signed({2'b00, cur_pos}) - $signed({2'b00, last_reg});

    always_comb
    begin
        diff_wrap = diff_raw;
        if (diff_raw > HALF_TURN)
        begin
            diff_wrap = diff_raw - FULL_TURN;
        end
        else if (diff_raw < -HALF_TURN)
        begin
            diff_wrap = diff_raw + FULL_TURN;
        end
    end

    assign diff       = diff_wrap[DIFF_W-1:0];
    assign speed_full = $signed({{(RATE_W+1){diff[DIFF_W-1]}}, diff})
                      * $signed({{(DIFF_W+1){1'b0}}, rate_reg});

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (report_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            rate_reg      <= RATE_RESET;
            last_reg      <= '0;
            total_reg     <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                rate_reg <= report_rate_hz;
            end
            if (report_fire)
            begin
                last_reg  <= cur_pos;
                total_reg <= total_reg + {{(TOTAL_W-DIFF_W){diff[DIFF_W-1]}}, diff};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_func_reg  <= func_t'(func);
            s1_angle_reg <= read_ok ? {angle_high, angle_low[LOW_W-1:0]} : '0;
        end
        if (report_fire)
        begin
            speed_reg <= speed_full[SPEED_W-1:0];
        end
    end

    assign out_valid   = out_valid_reg;
    assign position    = last_reg;
    assign total_ticks = total_reg;
    assign speed_q14   = speed_reg;

    `MAT_ASSERT_NOW(a_result_from_report, $rose(out_valid_reg), $past(report_fire),
        "result appeared without a report beat")
    `MAT_ASSERT_NEXT(a_total_holds, !report_fire, $stable(total_reg) && $stable(last_reg),
        "tick total or last position moved without a report")
    `MAT_ASSERT_NOW(a_stall_cause, !in_ready,
        s1_valid_reg && (s1_func_reg == FUNC_REPORT) && out_valid_reg && !out_ready,
        "input stalled without a blocked report")

endmodule
